[src/dnle_pkg.sv]
`timescale 1ns / 1ps

package dnle_pkg;

  localparam int DEFAULT_MAX_LABEL_BYTES = 63;

  localparam logic [7:0] DOT_CHAR    = 8'h2e;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] CNT_ONE = 2'd1;
  localparam logic [1:0] CNT_TWO = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       from_ram;
    logic       last;
    logic       term;
    logic [7:0] value;
  } fetch_t;

  typedef struct packed {
    logic issue_ok;
    logic half_busy;
  } pk_status_t;

endpackage

[src/dnle_ram.sv]
`timescale 1ns / 1ps

module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/dnle_seq.sv]
`timescale 1ns / 1ps

module dnle_seq import dnle_pkg::*; #(
  parameter int MAX_LABEL_BYTES = DEFAULT_MAX_LABEL_BYTES,
  localparam int ADDR_W = (MAX_LABEL_BYTES > 1) ? $clog2(MAX_LABEL_BYTES) : 1,
  localparam int LEN_W  = $clog2(MAX_LABEL_BYTES + 1),
  localparam int POS_W  = LEN_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  pk_status_t        status,
  output fetch_t            fetch,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [7:0]        ram_wr_data,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] n;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] total;

  logic             accept;
  logic             is_dot;
  logic             room;
  logic [LEN_W-1:0] len_next;
  logic [POS_W-1:0] total_next;
  logic [POS_W-1:0] pos_m1;
  logic             issue;
  logic             is_len_byte;
  logic             is_store_byte;

  assign s_tready = (state == ST_IDLE) && !fetch.valid && !status.half_busy;
  assign accept   = s_tvalid && s_tready;
  assign is_dot   = (s_tdata == DOT_CHAR);
  assign room     = (len < LEN_W'(MAX_LABEL_BYTES));

  always_comb begin
    ram_wr_data = s_tdata;
    if (s_tdata >= UPPER_A && s_tdata <= UPPER_Z) begin
      ram_wr_data = s_tdata + CASE_OFFSET;
    end
  end

  assign ram_wr_en   = accept && !is_dot && room;
  assign ram_wr_addr = len[ADDR_W-1:0];
  assign len_next    = ram_wr_en ? len + LEN_W'(1) : len;
  assign total_next  = ((len_next != '0) ? POS_W'(len_next) + POS_W'(1) : '0)
                       + POS_W'(s_tlast);

  assign issue         = (state == ST_RUN) && status.issue_ok;
  assign is_len_byte   = (n != '0) && (pos == '0);
  assign is_store_byte = (n != '0) && (pos != '0) && (pos <= POS_W'(n));
  assign pos_m1        = pos - POS_W'(1);
  assign ram_rd_en     = issue && is_store_byte;
  assign ram_rd_addr   = pos_m1[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      len         <= '0;
      fetch.valid <= 1'b0;
    end else begin
      fetch.valid <= issue;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_dot || s_tlast) begin
              len   <= '0;
              n     <= len_next;
              pos   <= '0;
              total <= total_next;
              if (total_next != '0) begin
                state <= ST_RUN;
              end
            end else begin
              len <= len_next;
            end
          end
        end
        ST_RUN: begin
          if (issue) begin
            fetch.from_ram <= is_store_byte;
            fetch.value    <= is_len_byte ? 8'(n) : 8'h00;
            fetch.term     <= !is_len_byte && !is_store_byte;
            fetch.last     <= (pos == total - POS_W'(1));
            if (pos == total - POS_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              pos <= pos + POS_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_LABEL_BYTES))
    else $error("label length beyond limit");

  a_rd_in_label: assert property (@(posedge clk) disable iff (rst)
    ram_rd_en |-> (pos != '0) && (pos <= POS_W'(n)))
    else $error("read outside the open label");

  a_plain_no_run: assert property (@(posedge clk) disable iff (rst)
    accept && !is_dot && !s_tlast |=> state == ST_IDLE)
    else $error("plain character started output");
`endif

endmodule

[src/dnle_pack.sv]
`timescale 1ns / 1ps

module dnle_pack import dnle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fetch_t      fetch,
  input  logic [7:0]  rd_data,
  output pk_status_t  status,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  logic       half_valid;
  logic [7:0] half_byte;
  logic       half_term;

  logic       out_valid;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [1:0] out_count;
  logic       out_done;
  logic       out_last;

  logic [7:0] byte_in;
  logic       push;

  assign byte_in = fetch.from_ram ? rd_data : fetch.value;
  assign push    = fetch.valid && (half_valid || fetch.last);

  assign status.issue_ok  = !out_valid && !push;
  assign status.half_busy = half_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (fetch.valid) begin
        if (!half_valid) begin
          if (fetch.last) begin
            out_valid  <= 1'b1;
            out_first  <= byte_in;
            out_second <= 8'h00;
            out_count  <= CNT_ONE;
            out_done   <= fetch.term;
            out_last   <= 1'b1;
          end else begin
            half_valid <= 1'b1;
            half_byte  <= byte_in;
            half_term  <= fetch.term;
          end
        end else begin
          half_valid <= 1'b0;
          out_valid  <= 1'b1;
          out_first  <= half_byte;
          out_second <= byte_in;
          out_count  <= CNT_TWO;
          out_done   <= half_term || fetch.term;
          out_last   <= fetch.last;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_count, out_second, out_first};
  assign m_tuser  = out_done;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> !out_valid)
    else $error("result pushed into a full output register");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count == CNT_ONE) |-> out_last)
    else $error("single byte result not last");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_last)
    else $error("terminator not in last result");
`endif

endmodule

[src/dns_name_label_encoder.sv]
`timescale 1ns / 1ps
// path: a closing item starts the label read-back; each fetch is registered, then packed
// throughput: one item per cycle for plain characters; after a closing item the input
// is held off until its label is read back and packed
// a two byte result is held in the output register while m_tready is low
// reset: rst is synchronous, active high; clears label length and all valid flags,
// label bytes in ram are not cleared and are only read after being written

module dns_name_label_encoder import dnle_pkg::*; #(
  parameter int MAX_LABEL_BYTES = DEFAULT_MAX_LABEL_BYTES,
  localparam int ADDR_W = (MAX_LABEL_BYTES > 1) ? $clog2(MAX_LABEL_BYTES) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_value
  input  logic        s_tlast,   // name_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // first_byte, second_byte, byte_count, zero pad
  output logic        m_tuser,   // name_done
  output logic        m_tlast    // run_last
);

  fetch_t            fetch;
  pk_status_t        status;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  dnle_seq #(
    .MAX_LABEL_BYTES(MAX_LABEL_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .status     (status),
    .fetch      (fetch),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr)
  );

  dnle_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LABEL_BYTES)
  ) u_label_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  dnle_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .fetch   (fetch),
    .rd_data (ram_rd_data),
    .status  (status),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

[verif/tb_dns_name_label_encoder.sv]
`timescale 1ns / 1ps

module tb_dns_name_label_encoder;
  import dnle_pkg::*;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       name_done;
    logic       run_last;
  } wire_word_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic receiver_held = 1'b0;
  int errors = 0;
  event long_stall_go;

  logic [7:0] label_bytes [0:62];
  int open_len = 0;
  logic [7:0] wire_bytes [$];
  wire_word_t expected_words [$];
  wire_word_t head_word;

  dns_name_label_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic void close_open_label();
    if (open_len != 0) begin
      wire_bytes.push_back(8'(open_len));
      for (int i = 0; i < open_len; i++) begin
        wire_bytes.push_back(label_bytes[i]);
      end
      open_len = 0;
    end
  endfunction

  function automatic void encode_char(input logic [7:0] ch, input logic name_end);
    logic [7:0] folded;
    int term_at;
    int n;
    wire_word_t w;
    folded = ch;
    term_at = -1;
    wire_bytes.delete();
    if (ch >= UPPER_A && ch <= UPPER_Z) begin
      folded = ch + CASE_OFFSET;
    end
    if (ch == DOT_CHAR) begin
      close_open_label();
    end else if (open_len < DEFAULT_MAX_LABEL_BYTES) begin
      label_bytes[open_len] = folded;
      open_len++;
    end
    if (name_end) begin
      close_open_label();
      term_at = wire_bytes.size();
      wire_bytes.push_back(8'h00);
    end
    for (int k = 0; k < wire_bytes.size(); k += 2) begin
      n = (wire_bytes.size() - k >= 2) ? 2 : 1;
      w.first_byte  = wire_bytes[k];
      w.second_byte = (n == 2) ? wire_bytes[k + 1] : 8'h00;
      w.byte_count  = (n == 2) ? CNT_TWO : CNT_ONE;
      w.name_done   = (term_at >= k) && (term_at < k + n);
      w.run_last    = (k + n >= wire_bytes.size());
      expected_words.push_back(w);
    end
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual tdata %h tuser %b tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        head_word = expected_words.pop_front();
        check_field("first_byte", head_word.first_byte, m_tdata[7:0]);
        check_field("second_byte", head_word.second_byte, m_tdata[15:8]);
        check_field("byte_count", {6'd0, head_word.byte_count}, {6'd0, m_tdata[17:16]});
        check_field("tdata pad", 8'h00, {2'b00, m_tdata[23:18]});
        check_field("name_done", {7'd0, head_word.name_done}, {7'd0, m_tuser});
        check_field("run_last", {7'd0, head_word.run_last}, {7'd0, m_tlast});
      end
    end
  end

  always @(posedge clk) begin
    if (receiver_held) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(long_stall_go);
      @(posedge clk);
      receiver_held <= 1'b1;
      repeat (300) @(posedge clk);
      receiver_held <= 1'b0;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic name_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= name_end;
    encode_char(ch, name_end);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'h61 + 8'($urandom_range(0, 25));
      1: c = UPPER_A + 8'($urandom_range(0, 25));
      2: c = ($urandom_range(0, 10) == 0) ? 8'h2d : 8'h30 + 8'($urandom_range(0, 9));
      default: begin
        c = 8'($urandom_range(0, 255));
        if (c == DOT_CHAR) begin
          c = 8'h2d;
        end
      end
    endcase
    return c;
  endfunction

  function automatic int label_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return 0;
    end else if (r == 1) begin
      case ($urandom_range(0, 3))
        0: return 62;
        1: return 63;
        2: return 64;
        default: return $urandom_range(65, 80);
      endcase
    end
    return $urandom_range(1, 12);
  endfunction

  task automatic test_root();
    send_name(".");
    wait_drain();
  endtask

  task automatic test_case_bounds();
    send_name("@AZ[`az{");
    send_name("Q");
    wait_drain();
  endtask

  task automatic test_empty_labels();
    send_name(".b..c.");
    wait_drain();
  endtask

  task automatic test_raw_bytes();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(DOT_CHAR, 1'b0);
    send_char(8'h2d, 1'b0);
    send_char(8'h2f, 1'b1);
    wait_drain();
  endtask

  task automatic test_long_label();
    for (int i = 0; i < 64; i++) begin
      send_char(UPPER_A + 8'(i % 26), i == 63);
    end
    wait_drain();
  endtask

  task automatic test_random_names(input int item_goal);
    logic [7:0] name [$];
    int sent;
    int labels;
    int len;
    logic trailing;
    sent = 0;
    while (sent < item_goal) begin
      name.delete();
      if ($urandom_range(0, 9) == 0) begin
        // noise with stray dots and ends
        repeat ($urandom_range(1, 8)) begin
          send_char(($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255)),
                    $urandom_range(0, 7) == 0);
          sent++;
        end
      end else begin
        labels = $urandom_range(1, 4);
        trailing = $urandom_range(0, 1);
        for (int l = 0; l < labels; l++) begin
          len = label_size();
          for (int i = 0; i < len; i++) begin
            name.push_back(label_char());
          end
          if (l < labels - 1 || trailing) begin
            name.push_back(DOT_CHAR);
          end
        end
        if (name.size() == 0) begin
          name.push_back(DOT_CHAR);
        end
        foreach (name[i]) begin
          send_char(name[i], i == name.size() - 1);
        end
        sent += name.size();
      end
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> long_stall_go;
    test_random_names(45);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 49;
    test_root();
    test_case_bounds();
    test_empty_labels();
    test_raw_bytes();
    test_long_label();
    test_random_names(70);
    send_idle_pct = 49;
    recv_idle_pct = 21;
    test_random_names(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_names(55);
    test_backpressure();
    if (errors == 0) begin
      $display("** dns_name_label_encoder: PASSED **");
    end else begin
      $display("** dns_name_label_encoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** dns_name_label_encoder: FAILED **");
    $finish;
  end

endmodule
